/* design/sba_pkg.sv */
package sba_pkg;

    localparam int NUM_SLOTS   = 256;
    localparam int INDEX_REACH = 256;
    localparam int ACTIVE_MAX  = (NUM_SLOTS < INDEX_REACH) ? NUM_SLOTS : INDEX_REACH;

    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (ACTIVE_MAX + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TEST    = 2'd2,
        OP_SCAN    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  bit_pos;
        logic [WORD_W-1:0] set_word;
    } eval_t;

endpackage

/* design/sba_ram.sv */
module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/sba_word_eval.sv */
module sba_word_eval (
    input  logic [sba_pkg::WORD_W-1:0]  word_data,
    input  logic [sba_pkg::WADDR_W-1:0] word_index,
    input  logic                        find_free,
    input  logic [sba_pkg::BIT_W-1:0]   start_bit,
    input  logic [sba_pkg::CNT_W-1:0]   count,
    output sba_pkg::eval_t              eval
);

    logic [sba_pkg::WORD_W-1:0] limit_mask;
    logic [sba_pkg::WORD_W-1:0] start_mask;
    logic [sba_pkg::WORD_W-1:0] cand;
    logic [sba_pkg::CNT_W-1:0]  slot;
    logic [sba_pkg::BIT_W-1:0]  pos;

    always_comb
    begin
        for (int b = 0; b < sba_pkg::WORD_W; b++)
        begin
            slot = (sba_pkg::CNT_W'(word_index) << sba_pkg::BIT_W)
                   | sba_pkg::CNT_W'(b);
            limit_mask[b] = (slot < count);
            start_mask[b] = (sba_pkg::BIT_W'(b) >= start_bit);
        end

        // allocate looks for a zero, scan for a one
        if (find_free)
        begin
            cand = ~word_data & limit_mask;
        end
        else
        begin
            cand = word_data & limit_mask & start_mask;
        end

        pos = '0;
        for (int b = sba_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                pos = sba_pkg::BIT_W'(b);
            end
        end

        eval.found    = |cand;
        eval.bit_pos  = pos;
        eval.set_word = word_data | (sba_pkg::WORD_W'(1) << pos);
    end

endmodule

/* design/slot_bitmap_allocator.sv */
// flow: an out-of-range beat goes straight to S_DONE, a release or test passes S_RUN,
// and an allocate or scan stays in S_RUN while it walks words; S_DONE waits for a free
// output register, then sets out_valid. One request at a time; the walk reads one
// 32-bit bitmap word per cycle through the single read port of the bitmap ram
// reset: rst_n clears control, sets the slot count to 256 and clears per-word valid flags,
// so the bitmap reads as all free at once with no clearing pass
module slot_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sba_pkg::OP_W-1:0]      operation,
    input  logic [sba_pkg::IDX_W-1:0]     slot_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sba_pkg::STATUS_W-1:0]  status,
    output logic [sba_pkg::IDX_W-1:0]     slot_result,
    output logic                          is_set,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sba_pkg::CNT_W-1:0]     slots_in_use
);

    sba_pkg::state_t state_reg, state_next;
    sba_pkg::op_t    op_reg, op_next;
    logic [sba_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [sba_pkg::WADDR_W-1:0] word_reg, word_next;
    logic                        first_reg, first_next;
    logic [sba_pkg::CNT_W-1:0]   cfg_reg;
    logic [sba_pkg::NUM_WORDS-1:0] valid_reg, valid_next;

    sba_pkg::status_t           res_status_reg, res_status_next;
    logic [sba_pkg::IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic                       res_set_reg, res_set_next;

    logic                       out_valid_reg;
    sba_pkg::status_t           out_status_reg;
    logic [sba_pkg::IDX_W-1:0]  out_slot_reg;
    logic                       out_set_reg;
    logic                       out_load;

    logic [sba_pkg::CNT_W-1:0]   count;
    logic [sba_pkg::WADDR_W-1:0] last_word;
    logic [sba_pkg::BIT_W-1:0]   idx_bit;
    logic [sba_pkg::BIT_W-1:0]   start_bit;
    logic [sba_pkg::WORD_W-1:0]  word_data;
    logic [sba_pkg::WORD_W-1:0]  ram_rdata;
    logic [sba_pkg::WORD_W-1:0]  ram_wdata;
    logic [sba_pkg::WADDR_W-1:0] ram_raddr;
    logic                        ram_we;
    logic [sba_pkg::IDX_W-1:0]   found_slot;
    logic                        in_beat;
    sba_pkg::op_t                in_op;
    sba_pkg::eval_t              eval;

    assign count = (cfg_reg > sba_pkg::CNT_W'(sba_pkg::ACTIVE_MAX))
                   ? sba_pkg::CNT_W'(sba_pkg::ACTIVE_MAX) : cfg_reg;
    assign last_word  = sba_pkg::WADDR_W'((count - sba_pkg::CNT_W'(1)) >> sba_pkg::BIT_W);
    assign idx_bit    = idx_reg[sba_pkg::BIT_W-1:0];
    assign start_bit  = first_reg ? idx_bit : '0;
    assign word_data  = valid_reg[word_reg] ? ram_rdata : '0;
    assign found_slot = sba_pkg::IDX_W'((sba_pkg::CNT_W'(word_reg) << sba_pkg::BIT_W)
                                        | sba_pkg::CNT_W'(eval.bit_pos));
    assign in_ready   = (state_reg == sba_pkg::S_IDLE);
    assign in_beat    = in_valid && in_ready;
    assign in_op      = sba_pkg::op_t'(operation);
    assign cfg_ready  = 1'b1;

    sba_ram #(
        .WIDTH(sba_pkg::WORD_W),
        .DEPTH(sba_pkg::NUM_WORDS)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(word_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sba_word_eval u_eval (
        .word_data (word_data),
        .word_index(word_reg),
        .find_free (op_reg == sba_pkg::OP_ALLOC),
        .start_bit (start_bit),
        .count     (count),
        .eval      (eval)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        first_next      = first_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_set_next    = res_set_reg;
        ram_we          = 1'b0;
        ram_wdata       = word_data;
        ram_raddr       = word_reg + sba_pkg::WADDR_W'(1);
        out_load        = 1'b0;

        case (state_reg)
            sba_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next         = in_op;
                    idx_next        = slot_index;
                    first_next      = 1'b1;
                    res_status_next = sba_pkg::ST_OK;
                    res_slot_next   = '0;
                    res_set_next    = 1'b0;
                    if (in_op == sba_pkg::OP_ALLOC)
                    begin
                        word_next = '0;
                    end
                    else
                    begin
                        word_next = sba_pkg::WADDR_W'(slot_index >> sba_pkg::BIT_W);
                    end
                    ram_raddr = word_next;
                    if (in_op == sba_pkg::OP_ALLOC && count == '0)
                    begin
                        res_status_next = sba_pkg::ST_NONE;
                        state_next      = sba_pkg::S_DONE;
                    end
                    else if (in_op != sba_pkg::OP_ALLOC
                             && sba_pkg::CNT_W'(slot_index) >= count)
                    begin
                        res_status_next = sba_pkg::ST_RANGE;
                        state_next      = sba_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = sba_pkg::S_RUN;
                    end
                end
            end

            sba_pkg::S_RUN:
            begin
                first_next = 1'b0;
                case (op_reg)
                    sba_pkg::OP_RELEASE:
                    begin
                        ram_we               = 1'b1;
                        ram_wdata            = word_data & ~(sba_pkg::WORD_W'(1) << idx_bit);
                        valid_next[word_reg] = 1'b1;
                        state_next           = sba_pkg::S_DONE;
                    end
                    sba_pkg::OP_TEST:
                    begin
                        res_set_next = word_data[idx_bit];
                        state_next   = sba_pkg::S_DONE;
                    end
                    default:
                    begin
                        if (eval.found)
                        begin
                            res_slot_next = found_slot;
                            state_next    = sba_pkg::S_DONE;
                            if (op_reg == sba_pkg::OP_ALLOC)
                            begin
                                ram_we               = 1'b1;
                                ram_wdata            = eval.set_word;
                                valid_next[word_reg] = 1'b1;
                            end
                        end
                        else if (word_reg == last_word)
                        begin
                            res_status_next = sba_pkg::ST_NONE;
                            state_next      = sba_pkg::S_DONE;
                        end
                        else
                        begin
                            word_next = word_reg + sba_pkg::WADDR_W'(1);
                        end
                    end
                endcase
            end

            sba_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sba_pkg::S_IDLE;
            valid_reg     <= '0;
            cfg_reg       <= sba_pkg::CNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= slots_in_use;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_set_reg    <= res_set_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_set_reg    <= res_set_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_result = out_slot_reg;
    assign is_set      = out_set_reg;

endmodule
